// ===== sv/pbb_pkg.sv =====
package pbb_pkg;

  localparam int BOX_BITS = 18;
  localparam int SUM_BITS = 34;

  localparam logic [BOX_BITS-1:0] BOX_ONES = {BOX_BITS{1'b1}};
  localparam logic [SUM_BITS-1:0] BOX_MAX =
    {{(SUM_BITS-BOX_BITS){1'b0}}, {BOX_BITS{1'b1}}};
  localparam logic [SUM_BITS-1:0] LINE_WIDEN = SUM_BITS'(2);

  localparam logic [1:0] ACT_HEADER = 2'd0;
  localparam logic [1:0] ACT_VERTEX = 2'd1;
  localparam logic [1:0] ACT_LAST   = 2'd2;

  localparam logic [3:0] KIND_NONE     = 4'd0;
  localparam logic [3:0] KIND_CUBE     = 4'd1;
  localparam logic [3:0] KIND_RECT     = 4'd2;
  localparam logic [3:0] KIND_LINE     = 4'd3;
  localparam logic [3:0] KIND_POLY     = 4'd4;
  localparam logic [3:0] KIND_PYR_EAST = 4'd5;
  localparam logic [3:0] KIND_PYR_WEST = 4'd6;
  localparam logic [3:0] KIND_PYR_UP   = 4'd7;
  localparam logic [3:0] KIND_PYR_DOWN = 4'd8;
  localparam logic [3:0] KIND_PYR_NRTH = 4'd9;
  localparam logic [3:0] KIND_PYR_STH  = 4'd10;

  // control from the input stage to the running box tracker
  typedef struct packed {
    logic       fire;
    logic       header;
    logic       line;
    logic       poly;
    logic       vertex;
    logic       last;
    logic [2:0] line_off;
  } trk_ctl_t;

  function automatic logic [BOX_BITS-1:0] sat(input logic [SUM_BITS-1:0] v);
    return (v > BOX_MAX) ? BOX_ONES : v[BOX_BITS-1:0];
  endfunction

  // bit i set: axis i gets widened by two on degenerate lines
  function automatic logic [2:0] line_offsets(input logic [2:0] zero);
    logic [2:0] r;
    r = 3'b000;
    if (zero[0] && zero[1]) r = 3'b011;
    else if (zero[0] && zero[2]) r = 3'b101;
    else if (zero[1] && zero[2]) r = 3'b110;
    return r;
  endfunction

endpackage

// ===== sv/primitive_bounding_box.sv =====
// an accepted word goes through the input register and then the result register
// throughput: one word per cycle while out_ready does not hold the result
// register, set by the single pass between the input register and the result
// register; words that yield no result still take one slot of that pass
// reset: synchronous, active high; clears both stages and the running box
module primitive_bounding_box #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [3:0]                    kind,
  input  logic [COORD_BITS-1:0]         coord_x,
  input  logic [COORD_BITS-1:0]         coord_y,
  input  logic [COORD_BITS-1:0]         coord_z,
  input  logic [COORD_BITS-1:0]         extent_x,
  input  logic [COORD_BITS-1:0]         extent_y,
  input  logic [COORD_BITS-1:0]         extent_z,
  input  logic [COORD_BITS-1:0]         apex_a0,
  input  logic [COORD_BITS-1:0]         apex_a1,
  input  logic [COORD_BITS-1:0]         apex_a2,
  input  logic [COORD_BITS-1:0]         apex_a3,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          box_valid,
  output logic [pbb_pkg::BOX_BITS-1:0]  min_x,
  output logic [pbb_pkg::BOX_BITS-1:0]  min_y,
  output logic [pbb_pkg::BOX_BITS-1:0]  min_z,
  output logic [pbb_pkg::BOX_BITS-1:0]  max_x,
  output logic [pbb_pkg::BOX_BITS-1:0]  max_y,
  output logic [pbb_pkg::BOX_BITS-1:0]  max_z
);

  // input stage
  logic                          s1_valid;
  logic [1:0]                    s1_action;
  logic [3:0]                    s1_kind;
  logic [2:0][COORD_BITS-1:0]    s1_coord;
  logic [2:0][COORD_BITS-1:0]    s1_extent;
  logic [3:0][COORD_BITS-1:0]    s1_apex;

  logic                          advance;
  logic                          in_fire;

  logic                                  hdr_valid;
  logic [2:0][pbb_pkg::BOX_BITS-1:0]     hdr_lo;
  logic [2:0][pbb_pkg::BOX_BITS-1:0]     hdr_hi;
  logic [2:0]                            hdr_line_off;

  pbb_pkg::trk_ctl_t                     ctl;
  logic                                  trk_open;
  logic [2:0][pbb_pkg::BOX_BITS-1:0]     trk_min;
  logic [2:0][pbb_pkg::BOX_BITS-1:0]     trk_max;

  logic                                  is_header;
  logic                                  is_vertex;
  logic                                  hdr_result;
  logic                                  last_result;
  logic                                  has_result;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action <= action;
      s1_kind   <= kind;
      s1_coord  <= {coord_z, coord_y, coord_x};
      s1_extent <= {extent_z, extent_y, extent_x};
      s1_apex   <= {apex_a3, apex_a2, apex_a1, apex_a0};
    end
  end

  pbb_header_box #(
    .COORD_BITS(COORD_BITS)
  ) u_header_box (
    .kind      (s1_kind),
    .coord     (s1_coord),
    .extent    (s1_extent),
    .apex      (s1_apex),
    .box_valid (hdr_valid),
    .lo        (hdr_lo),
    .hi        (hdr_hi),
    .line_off  (hdr_line_off)
  );

  assign is_header = (s1_action == pbb_pkg::ACT_HEADER);
  assign is_vertex = (s1_action == pbb_pkg::ACT_VERTEX) ||
                     (s1_action == pbb_pkg::ACT_LAST);

  always_comb begin
    ctl.fire     = advance;
    ctl.header   = is_header;
    ctl.line     = (s1_kind == pbb_pkg::KIND_LINE);
    ctl.poly     = (s1_kind == pbb_pkg::KIND_POLY);
    ctl.vertex   = is_vertex;
    ctl.last     = (s1_action == pbb_pkg::ACT_LAST);
    ctl.line_off = hdr_line_off;
  end

  pbb_vertex_track #(
    .COORD_BITS(COORD_BITS)
  ) u_vertex_track (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .coord   (s1_coord),
    .open    (trk_open),
    .upd_min (trk_min),
    .upd_max (trk_max)
  );

  // line and polygon headers only open the running box
  assign hdr_result  = is_header && !ctl.line && !ctl.poly;
  assign last_result = ctl.last && trk_open;
  assign has_result  = hdr_result || last_result;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      if (hdr_result) begin
        box_valid <= hdr_valid;
        min_x     <= hdr_lo[0];
        min_y     <= hdr_lo[1];
        min_z     <= hdr_lo[2];
        max_x     <= hdr_hi[0];
        max_y     <= hdr_hi[1];
        max_z     <= hdr_hi[2];
      end else begin
        box_valid <= 1'b1;
        min_x     <= trk_min[0];
        min_y     <= trk_min[1];
        min_z     <= trk_min[2];
        max_x     <= trk_max[0];
        max_y     <= trk_max[1];
        max_z     <= trk_max[2];
      end
    end
  end

`ifndef ASSERT_OFF
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid && box_valid |-> (min_x <= max_x) && (min_y <= max_y) && (min_z <= max_z))
    else $error("result box has min above max");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !box_valid |->
      (min_x == '0) && (min_y == '0) && (min_z == '0) &&
      (max_x == '0) && (max_y == '0) && (max_z == '0))
    else $error("empty box carries nonzero bounds");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while input stage is blocked");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("stages not empty after reset");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    advance && ctl.last |=> !trk_open)
    else $error("last vertex left the object open");
`endif

endmodule

// ===== sv/pbb_header_box.sv =====
module pbb_header_box #(
  parameter int COORD_BITS = 16
) (
  input  logic [3:0]                                 kind,
  input  logic [2:0][COORD_BITS-1:0]                 coord,
  input  logic [2:0][COORD_BITS-1:0]                 extent,
  input  logic [3:0][COORD_BITS-1:0]                 apex,
  output logic                                       box_valid,
  output logic [2:0][pbb_pkg::BOX_BITS-1:0]          lo,
  output logic [2:0][pbb_pkg::BOX_BITS-1:0]          hi,
  output logic [2:0]                                 line_off
);

  localparam int SW = pbb_pkg::SUM_BITS;

  logic [2:0] size_zero;
  logic [1:0] main_axis;
  logic       is_box;
  logic       is_pyr;
  logic [2:0][COORD_BITS-1:0] pyr_top;

  assign size_zero = {extent[2] == '0, extent[1] == '0, extent[0] == '0};
  assign line_off  = pbb_pkg::line_offsets(size_zero);

  always_comb begin
    is_box    = 1'b0;
    is_pyr    = 1'b0;
    main_axis = 2'd0;
    unique case (kind) inside
      pbb_pkg::KIND_CUBE, pbb_pkg::KIND_RECT: begin
        is_box = 1'b1;
      end
      pbb_pkg::KIND_PYR_EAST, pbb_pkg::KIND_PYR_WEST: begin
        is_pyr    = 1'b1;
        main_axis = 2'd0;
      end
      pbb_pkg::KIND_PYR_UP, pbb_pkg::KIND_PYR_DOWN: begin
        is_pyr    = 1'b1;
        main_axis = 2'd1;
      end
      pbb_pkg::KIND_PYR_NRTH, pbb_pkg::KIND_PYR_STH: begin
        is_pyr    = 1'b1;
        main_axis = 2'd2;
      end
      default: begin
        is_box = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [COORD_BITS-1:0] pa;
    logic [COORD_BITS-1:0] pb;
    logic [COORD_BITS-1:0] m1;
    logic                  widen;
    logic                  first_free;

    // free axes taken in x,y,z order: first uses a0/a2, second a1/a3
    assign first_free = (i == 0) || ((i == 1) && (main_axis == 2'd0));
    assign pa = first_free ? apex[0] : apex[1];
    assign pb = first_free ? apex[2] : apex[3];
    assign m1 = (pa > extent[i]) ? pa : extent[i];
    assign pyr_top[i] = ((main_axis == 2'(i)) || (pb <= m1)) ?
                        ((main_axis == 2'(i)) ? extent[i] : m1) : pb;
    assign widen = (kind == pbb_pkg::KIND_RECT) && line_off[i];

    always_comb begin
      lo[i] = '0;
      hi[i] = '0;
      if (is_box) begin
        lo[i] = pbb_pkg::sat(SW'(coord[i]));
        hi[i] = pbb_pkg::sat(SW'(coord[i]) + SW'(extent[i]) +
                             (widen ? pbb_pkg::LINE_WIDEN : '0));
      end else if (is_pyr) begin
        lo[i] = pbb_pkg::sat(SW'(coord[i]));
        hi[i] = pbb_pkg::sat(SW'(coord[i]) + SW'(pyr_top[i]));
      end
    end
  end

  assign box_valid = is_box || is_pyr;

endmodule

// ===== sv/pbb_vertex_track.sv =====
module pbb_vertex_track #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pbb_pkg::trk_ctl_t                   ctl,
  input  logic [2:0][COORD_BITS-1:0]          coord,
  output logic                                open,
  output logic [2:0][pbb_pkg::BOX_BITS-1:0]   upd_min,
  output logic [2:0][pbb_pkg::BOX_BITS-1:0]   upd_max
);

  localparam int SW = pbb_pkg::SUM_BITS;

  logic [2:0]                               off;
  logic [2:0][pbb_pkg::BOX_BITS-1:0]        run_min;
  logic [2:0][pbb_pkg::BOX_BITS-1:0]        run_max;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [pbb_pkg::BOX_BITS-1:0] v;
    logic [pbb_pkg::BOX_BITS-1:0] w;

    assign v = pbb_pkg::sat(SW'(coord[i]));
    assign w = pbb_pkg::sat(SW'(coord[i]) + (off[i] ? pbb_pkg::LINE_WIDEN : '0));
    assign upd_min[i] = (v < run_min[i]) ? v : run_min[i];
    assign upd_max[i] = (w > run_max[i]) ? w : run_max[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open    <= 1'b0;
      off     <= 3'b000;
      run_min <= {3{pbb_pkg::BOX_ONES}};
      run_max <= '0;
    end else if (ctl.fire) begin
      if (ctl.header) begin
        open    <= ctl.line || ctl.poly;
        off     <= ctl.line ? ctl.line_off : 3'b000;
        run_min <= {3{pbb_pkg::BOX_ONES}};
        run_max <= '0;
      end else if (ctl.vertex && open) begin
        run_min <= upd_min;
        run_max <= upd_max;
        if (ctl.last) begin
          open <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== bench/tb_primitive_bounding_box.sv =====
module tb_primitive_bounding_box;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 400;
  localparam int TAIL_CYCLES = 8;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [3:0] KIND_SPARE_LO = 4'd11;
  localparam logic [3:0] KIND_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [1:0]          action;
    logic [3:0]          kind;
    logic [2:0][CW-1:0]  c;
    logic [2:0][CW-1:0]  sz;
    logic [3:0][CW-1:0]  ap;
  } word_t;

  typedef struct packed {
    logic                               valid;
    logic [2:0][pbb_pkg::BOX_BITS-1:0]  lo;
    logic [2:0][pbb_pkg::BOX_BITS-1:0]  hi;
  } box_t;

  class box_scoreboard;
    logic [3:0]                         open_kind;
    logic [2:0]                         widen;
    logic [2:0][pbb_pkg::BOX_BITS-1:0]  run_lo;
    logic [2:0][pbb_pkg::BOX_BITS-1:0]  run_hi;
    box_t                               boxes_due[$];
    int                                 errors;

    function new();
      open_kind = pbb_pkg::KIND_NONE;
      widen = 3'b000;
      run_lo = {3{pbb_pkg::BOX_ONES}};
      run_hi = '0;
      errors = 0;
    endfunction

    function int pending();
      return boxes_due.size();
    endfunction

    function void expect_box(box_t b);
      boxes_due.insert(boxes_due.size(), b);
    endfunction

    function logic [pbb_pkg::BOX_BITS-1:0] clip(int v);
      logic [31:0] u;
      u = v;
      return (u > 32'(pbb_pkg::BOX_ONES)) ? pbb_pkg::BOX_ONES : u[pbb_pkg::BOX_BITS-1:0];
    endfunction

    // degenerate line: pick the pair of zero-size axes, x/y first
    function logic [2:0] thin_axes(logic [2:0] zero);
      if (zero[0] && zero[1]) return 3'b011;
      if (zero[0] && zero[2]) return 3'b101;
      if (zero[1] && zero[2]) return 3'b110;
      return 3'b000;
    endfunction

    task report_mismatch(string what, logic [pbb_pkg::BOX_BITS-1:0] got,
                         logic [pbb_pkg::BOX_BITS-1:0] want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      errors++;
    endtask

    function void note_word(word_t w);
      box_t want;
      logic [2:0] zero;
      logic [2:0] thin;
      int main_axis;
      int f;
      int top;
      want = '0;
      for (int a = 0; a < 3; a++) zero[a] = (w.sz[a] == '0);
      thin = thin_axes(zero);
      if (w.action == pbb_pkg::ACT_HEADER) begin
        open_kind = w.kind;
        widen = 3'b000;
        run_lo = {3{pbb_pkg::BOX_ONES}};
        run_hi = '0;
        case (w.kind)
          pbb_pkg::KIND_LINE: begin
            widen = thin;
          end
          pbb_pkg::KIND_POLY: begin
          end
          pbb_pkg::KIND_CUBE, pbb_pkg::KIND_RECT: begin
            want.valid = 1'b1;
            for (int a = 0; a < 3; a++) begin
              want.lo[a] = clip(int'(w.c[a]));
              top = int'(w.c[a]) + int'(w.sz[a]);
              if (w.kind == pbb_pkg::KIND_RECT && thin[a]) top += 2;
              want.hi[a] = clip(top);
            end
            expect_box(want);
          end
          pbb_pkg::KIND_PYR_EAST, pbb_pkg::KIND_PYR_WEST, pbb_pkg::KIND_PYR_UP,
          pbb_pkg::KIND_PYR_DOWN, pbb_pkg::KIND_PYR_NRTH, pbb_pkg::KIND_PYR_STH: begin
            want.valid = 1'b1;
            main_axis = int'(w.kind - pbb_pkg::KIND_PYR_EAST) >> 1;
            f = 0;
            for (int a = 0; a < 3; a++) begin
              want.lo[a] = clip(int'(w.c[a]));
              top = int'(w.sz[a]);
              if (a != main_axis) begin
                // free axis takes apex bounds f and f+2
                if (int'(w.ap[f]) > top) top = int'(w.ap[f]);
                if (int'(w.ap[f+2]) > top) top = int'(w.ap[f+2]);
                f++;
              end
              want.hi[a] = clip(int'(w.c[a]) + top);
            end
            expect_box(want);
          end
          default: begin
            expect_box(want);
          end
        endcase
      end else if (w.action == pbb_pkg::ACT_VERTEX || w.action == pbb_pkg::ACT_LAST) begin
        if (open_kind == pbb_pkg::KIND_LINE || open_kind == pbb_pkg::KIND_POLY) begin
          for (int a = 0; a < 3; a++) begin
            if (pbb_pkg::BOX_BITS'(w.c[a]) < run_lo[a])
              run_lo[a] = pbb_pkg::BOX_BITS'(w.c[a]);
            top = int'(w.c[a]) + (widen[a] ? 2 : 0);
            if (clip(top) > run_hi[a]) run_hi[a] = clip(top);
          end
          if (w.action == pbb_pkg::ACT_LAST) begin
            open_kind = pbb_pkg::KIND_NONE;
            want.valid = 1'b1;
            want.lo = run_lo;
            want.hi = run_hi;
            expect_box(want);
          end
        end
      end
    endfunction

    task check_box(box_t got);
      box_t want;
      if (boxes_due.size() == 0) begin
        report_mismatch("result word with nothing expected, box_valid",
                        pbb_pkg::BOX_BITS'(got.valid), '0);
        return;
      end
      want = boxes_due.pop_front();
      if (got.valid !== want.valid)
        report_mismatch("box_valid", pbb_pkg::BOX_BITS'(got.valid),
                        pbb_pkg::BOX_BITS'(want.valid));
      for (int a = 0; a < 3; a++) begin
        if (got.lo[a] !== want.lo[a])
          report_mismatch($sformatf("min axis %0d", a), got.lo[a], want.lo[a]);
        if (got.hi[a] !== want.hi[a])
          report_mismatch($sformatf("max axis %0d", a), got.hi[a], want.hi[a]);
      end
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = '0;
  logic [3:0] kind = '0;
  logic [CW-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [CW-1:0] extent_x = '0, extent_y = '0, extent_z = '0;
  logic [CW-1:0] apex_a0 = '0, apex_a1 = '0, apex_a2 = '0, apex_a3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic box_valid;
  logic [pbb_pkg::BOX_BITS-1:0] min_x, min_y, min_z, max_x, max_y, max_z;

  box_scoreboard sb;
  int send_idle = 0;
  int recv_idle = 0;
  int words_sent = 0;
  int cycles = 0;

  primitive_bounding_box uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .kind(kind),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .extent_x(extent_x), .extent_y(extent_y), .extent_z(extent_z),
    .apex_a0(apex_a0), .apex_a1(apex_a1), .apex_a2(apex_a2), .apex_a3(apex_a3),
    .out_valid(out_valid), .out_ready(out_ready),
    .box_valid(box_valid),
    .min_x(min_x), .min_y(min_y), .min_z(min_z),
    .max_x(max_x), .max_y(max_y), .max_z(max_z)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin : watch_results
    box_t seen;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      seen.valid = box_valid;
      seen.lo = {min_z, min_y, min_x};
      seen.hi = {max_z, max_y, max_x};
      sb.check_box(seen);
    end
  end

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic word_t random_word(logic [1:0] act, logic [3:0] knd);
    word_t w;
    w.action = act;
    w.kind = knd;
    for (int a = 0; a < 3; a++) begin
      w.c[a] = pick_coord();
      w.sz[a] = pick_coord();
    end
    for (int a = 0; a < 4; a++) w.ap[a] = pick_coord();
    return w;
  endfunction

  task automatic send_word(input word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    action <= w.action;
    kind <= w.kind;
    coord_x <= w.c[0];
    coord_y <= w.c[1];
    coord_z <= w.c[2];
    extent_x <= w.sz[0];
    extent_y <= w.sz[1];
    extent_z <= w.sz[2];
    apex_a0 <= w.ap[0];
    apex_a1 <= w.ap[1];
    apex_a2 <= w.ap[2];
    apex_a3 <= w.ap[3];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_word(w);
    words_sent++;
  endtask

  // stop sending until every result word has been taken
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic send_directed();
    word_t w;
    w = random_word(pbb_pkg::ACT_HEADER, pbb_pkg::KIND_CUBE);
    w.c = {3{16'hffff}};
    w.sz = {3{16'hffff}};
    send_word(w);
    w.c = '0;
    w.sz = '0;
    send_word(w);
    // rectangles that collapse to lines, one per zero pair, then all zero
    for (int p = 0; p < 4; p++) begin
      w = random_word(pbb_pkg::ACT_HEADER, pbb_pkg::KIND_RECT);
      w.c = {3{16'hffff}};
      if (p != 2) w.sz[0] = '0;
      if (p != 1) w.sz[1] = '0;
      if (p != 0) w.sz[2] = '0;
      send_word(w);
    end
    for (int k = pbb_pkg::KIND_PYR_EAST; k <= pbb_pkg::KIND_PYR_STH; k++) begin
      w = random_word(pbb_pkg::ACT_HEADER, 4'(k));
      if (k[0]) begin
        w.ap = {4{16'hffff}};
        w.sz = '0;
      end
      send_word(w);
    end
    send_word(random_word(pbb_pkg::ACT_HEADER, pbb_pkg::KIND_NONE));
    send_word(random_word(pbb_pkg::ACT_HEADER, KIND_SPARE_HI));
    send_word(random_word(pbb_pkg::ACT_VERTEX, pbb_pkg::KIND_LINE));
    send_word(random_word(ACT_SPARE, pbb_pkg::KIND_CUBE));
    w = random_word(pbb_pkg::ACT_HEADER, pbb_pkg::KIND_LINE);
    w.sz[0] = '0;
    w.sz[1] = '0;
    send_word(w);
    w = random_word(pbb_pkg::ACT_VERTEX, pbb_pkg::KIND_NONE);
    w.c = {3{16'hffff}};
    send_word(w);
    w = random_word(pbb_pkg::ACT_LAST, pbb_pkg::KIND_NONE);
    w.c = '0;
    send_word(w);
    send_word(random_word(pbb_pkg::ACT_LAST, pbb_pkg::KIND_NONE));
    send_word(random_word(pbb_pkg::ACT_HEADER, pbb_pkg::KIND_POLY));
    send_word(random_word(pbb_pkg::ACT_VERTEX, pbb_pkg::KIND_POLY));
    send_word(random_word(pbb_pkg::ACT_LAST, pbb_pkg::KIND_POLY));
    // an open line dropped by a new header
    send_word(random_word(pbb_pkg::ACT_HEADER, pbb_pkg::KIND_LINE));
    send_word(random_word(pbb_pkg::ACT_VERTEX, pbb_pkg::KIND_LINE));
    send_word(random_word(pbb_pkg::ACT_HEADER, pbb_pkg::KIND_POLY));
    send_word(random_word(pbb_pkg::ACT_LAST, pbb_pkg::KIND_POLY));
  endtask

  task automatic send_random_object();
    word_t w;
    logic [3:0] k;
    int n;
    if ($urandom_range(99) < 8) begin
      send_word(random_word(2'($urandom_range(3)), 4'($urandom_range(15))));
      return;
    end
    case ($urandom_range(9))
      0: k = pbb_pkg::KIND_CUBE;
      1: k = pbb_pkg::KIND_RECT;
      2, 3: k = pbb_pkg::KIND_LINE;
      4, 5: k = pbb_pkg::KIND_POLY;
      6, 7, 8: k = 4'($urandom_range(pbb_pkg::KIND_PYR_STH, pbb_pkg::KIND_PYR_EAST));
      default: k = $urandom_range(1) ? pbb_pkg::KIND_NONE
                                     : 4'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
    endcase
    w = random_word(pbb_pkg::ACT_HEADER, k);
    if ((k == pbb_pkg::KIND_RECT || k == pbb_pkg::KIND_LINE) && $urandom_range(1)) begin
      for (int a = 0; a < 3; a++) if ($urandom_range(1)) w.sz[a] = '0;
    end
    send_word(w);
    if (k == pbb_pkg::KIND_LINE || k == pbb_pkg::KIND_POLY) begin
      n = $urandom_range(5);
      repeat (n) send_word(random_word(pbb_pkg::ACT_VERTEX, 4'($urandom_range(15))));
      if ($urandom_range(9) != 0)
        send_word(random_word(pbb_pkg::ACT_LAST, 4'($urandom_range(15))));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_directed();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 34; recv_idle = 64; end
        1: begin send_idle = 64; recv_idle = 34; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      words_sent = 0;
      while (words_sent < PHASE_WORDS) begin
        send_random_object();
        if ((phase == 0 && words_sent >= PHASE_WORDS / 2 && words_sent < PHASE_WORDS / 2 + 8)
            || $urandom_range(99) == 0)
          hold_until_drained();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pbb_pkg.sv
sv/pbb_header_box.sv
sv/pbb_vertex_track.sv
sv/primitive_bounding_box.sv
bench/tb_primitive_bounding_box.sv
